[hw/rtl/jsu_pkg.sv]
package jsu_pkg;

  // Result class carried on the output channel.
  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  // Error classes reported with KIND_ERROR.
  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_NO_QUOTE    = 3'd1,
    ERR_UNEXP_END   = 3'd2,
    ERR_BAD_ESCAPE  = 3'd3,
    ERR_BAD_HEX     = 3'd4,
    ERR_UNPAIRED_HI = 3'd5,
    ERR_BAD_LOW     = 3'd6
  } err_e;

  localparam int unsigned MaxResults = 4;
  localparam int unsigned IdxW       = $clog2(MaxResults);

  // All results that one input item causes, emitted in order 0..last_idx.
  typedef struct packed {
    logic [IdxW-1:0]             last_idx;
    logic [MaxResults-1:0][7:0]  bytes;
    kind_e                       kind;
    err_e                        code;
  } grp_t;

endpackage

[hw/rtl/jsu_if.sv]
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic [2:0] error_code;
  logic       last_of_run;

  modport source (output valid, output out_byte, output kind, output error_code,
                  output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input kind, input error_code,
                  input last_of_run, output ready);
endinterface

[hw/rtl/json_string_unescape_utf8_top.sv]
// JSON string unescaper: feed a quoted string token one byte per transaction,
// starting at the opening quote, and receive its decoded UTF-8 bytes, then a
// closing result (kind 1) or an error result (kind 2, with error_code), each
// marked last_of_run on the final result an input byte caused. Input bytes
// pass through an input register, are decoded combinationally against the
// parse state and land in a result buffer that holds up to four results.
// Throughput is one input transaction per cycle while each byte causes at
// most one result and the output is ready; a byte that completes a \u escape
// whose scalar takes n UTF-8 bytes occupies the result buffer until all n
// are emitted, one result per cycle while the output is ready.
module json_string_unescape_utf8_top
  import jsu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  jsu_in_if.sink    in_i,
  jsu_out_if.source out_o
);

  // Input register.
  logic       in_valid_q;
  logic [7:0] text_q;
  logic       eot_q;

  // Decode and result buffer handoff.
  logic grp_valid;
  grp_t grp;
  logic can_load;
  logic advance;
  logic load;

  // Advance the held byte when its results (if any) have room in the buffer;
  // bytes that cause no result advance regardless of the output side.
  assign advance   = in_valid_q && (!grp_valid || can_load);
  assign load      = advance && grp_valid;
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  // Capture payload on every accepted transaction.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      text_q <= in_i.text_byte;
      eot_q  <= in_i.end_of_text;
    end
  end

  jsu_parse u_parse (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (advance),
    .text_byte_i   (text_q),
    .end_of_text_i (eot_q),
    .grp_valid_o   (grp_valid),
    .grp_o         (grp)
  );

  jsu_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .grp_i      (grp),
    .can_load_o (can_load),
    .out_o      (out_o)
  );

endmodule

[hw/rtl/jsu_parse.sv]
module jsu_parse
  import jsu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       advance_i,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_text_i,
  output logic       grp_valid_o,
  output grp_t       grp_o
);

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_BODY    = 3'd1,
    MODE_ESC     = 3'd2,
    MODE_HEX     = 3'd3,
    MODE_PAIR_BS = 3'd4,
    MODE_PAIR_U  = 3'd5
  } mode_e;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChB = 8'h62;
  localparam logic [7:0] ChF = 8'h66;
  localparam logic [7:0] ChN = 8'h6E;
  localparam logic [7:0] ChR = 8'h72;
  localparam logic [7:0] ChT = 8'h74;
  localparam logic [7:0] ChU = 8'h75;

  mode_e       mode_q, mode_d;
  logic [11:0] hex_q, hex_d;
  logic [1:0]  digits_q, digits_d;
  logic [9:0]  held_q, held_d;
  logic        pending_q, pending_d;

  logic        nib_ok;
  logic [3:0]  nib;
  logic [15:0] hex_full;
  logic [10:0] pair_hi;
  logic [20:0] pair_scalar;

  function automatic grp_t one_result(kind_e kind, err_e code, logic [7:0] b);
    grp_t g;
    g          = '0;
    g.kind     = kind;
    g.code     = code;
    g.bytes[0] = b;
    return g;
  endfunction

  // UTF-8 encode one scalar into one to four bytes.
  function automatic grp_t encode(logic [20:0] s);
    grp_t g;
    g      = '0;
    g.kind = KIND_BYTE;
    g.code = ERR_NONE;
    if (s[20:7] == '0) begin
      g.last_idx = IdxW'(0);
      g.bytes[0] = {1'b0, s[6:0]};
    end else if (s[20:11] == '0) begin
      g.last_idx = IdxW'(1);
      g.bytes[0] = {3'b110, s[10:6]};
      g.bytes[1] = {2'b10, s[5:0]};
    end else if (s[20:16] == '0) begin
      g.last_idx = IdxW'(2);
      g.bytes[0] = {4'b1110, s[15:12]};
      g.bytes[1] = {2'b10, s[11:6]};
      g.bytes[2] = {2'b10, s[5:0]};
    end else begin
      g.last_idx = IdxW'(3);
      g.bytes[0] = {5'b11110, s[20:18]};
      g.bytes[1] = {2'b10, s[17:12]};
      g.bytes[2] = {2'b10, s[11:6]};
      g.bytes[3] = {2'b10, s[5:0]};
    end
    return g;
  endfunction

  // Hex digit decode: letters of either case map through their low nibble.
  always_comb begin
    nib_ok = 1'b0;
    nib    = text_byte_i[3:0];
    if (text_byte_i >= 8'h30 && text_byte_i <= 8'h39) begin
      nib_ok = 1'b1;
    end else if ((text_byte_i >= 8'h61 && text_byte_i <= 8'h66) ||
                 (text_byte_i >= 8'h41 && text_byte_i <= 8'h46)) begin
      nib_ok = 1'b1;
      nib    = text_byte_i[3:0] + 4'd9;
    end
  end

  // Pair scalar: 0x10000 is 64 units of 1024, so add 64 to the high half.
  assign hex_full    = {hex_q, nib};
  assign pair_hi     = {1'b0, held_q} + 11'd64;
  assign pair_scalar = {pair_hi, hex_full[9:0]};

  always_comb begin
    mode_d      = mode_q;
    hex_d       = hex_q;
    digits_d    = digits_q;
    held_d      = held_q;
    pending_d   = pending_q;
    grp_valid_o = 1'b0;
    grp_o       = '0;

    if (end_of_text_i) begin
      grp_valid_o = 1'b1;
      if (mode_q == MODE_PAIR_BS || mode_q == MODE_PAIR_U) begin
        grp_o = one_result(KIND_ERROR, ERR_UNPAIRED_HI, 8'h00);
      end else begin
        grp_o = one_result(KIND_ERROR, ERR_UNEXP_END, 8'h00);
      end
      mode_d    = MODE_IDLE;
      hex_d     = '0;
      digits_d  = '0;
      held_d    = '0;
      pending_d = 1'b0;
    end else begin
      unique case (mode_q)
        MODE_BODY: begin
          if (text_byte_i == ChQuote) begin
            grp_valid_o = 1'b1;
            grp_o       = one_result(KIND_END, ERR_NONE, 8'h00);
            mode_d      = MODE_IDLE;
          end else if (text_byte_i == ChBslash) begin
            mode_d = MODE_ESC;
          end else begin
            grp_valid_o = 1'b1;
            grp_o       = one_result(KIND_BYTE, ERR_NONE, text_byte_i);
          end
        end
        MODE_ESC: begin
          grp_valid_o = 1'b1;
          mode_d      = MODE_BODY;
          unique case (text_byte_i)
            ChQuote:  grp_o = one_result(KIND_BYTE, ERR_NONE, ChQuote);
            ChBslash: grp_o = one_result(KIND_BYTE, ERR_NONE, ChBslash);
            ChSlash:  grp_o = one_result(KIND_BYTE, ERR_NONE, ChSlash);
            ChB:      grp_o = one_result(KIND_BYTE, ERR_NONE, 8'h08);
            ChF:      grp_o = one_result(KIND_BYTE, ERR_NONE, 8'h0C);
            ChN:      grp_o = one_result(KIND_BYTE, ERR_NONE, 8'h0A);
            ChR:      grp_o = one_result(KIND_BYTE, ERR_NONE, 8'h0D);
            ChT:      grp_o = one_result(KIND_BYTE, ERR_NONE, 8'h09);
            ChU: begin
              grp_valid_o = 1'b0;
              mode_d      = MODE_HEX;
              hex_d       = '0;
              digits_d    = '0;
            end
            default: begin
              grp_o     = one_result(KIND_ERROR, ERR_BAD_ESCAPE, 8'h00);
              mode_d    = MODE_IDLE;
              hex_d     = '0;
              digits_d  = '0;
              held_d    = '0;
              pending_d = 1'b0;
            end
          endcase
        end
        MODE_HEX: begin
          if (!nib_ok) begin
            grp_valid_o = 1'b1;
            grp_o       = one_result(KIND_ERROR, ERR_BAD_HEX, 8'h00);
            mode_d      = MODE_IDLE;
            hex_d       = '0;
            digits_d    = '0;
            held_d      = '0;
            pending_d   = 1'b0;
          end else if (digits_q != 2'd3) begin
            hex_d    = hex_full[11:0];
            digits_d = digits_q + 2'd1;
          end else begin
            hex_d    = '0;
            digits_d = '0;
            if (pending_q) begin
              grp_valid_o = 1'b1;
              if (hex_full[15:10] != 6'b110111) begin
                grp_o  = one_result(KIND_ERROR, ERR_BAD_LOW, 8'h00);
                mode_d = MODE_IDLE;
              end else begin
                grp_o  = encode(pair_scalar);
                mode_d = MODE_BODY;
              end
              held_d    = '0;
              pending_d = 1'b0;
            end else if (hex_full[15:10] == 6'b110110) begin
              held_d    = hex_full[9:0];
              pending_d = 1'b1;
              mode_d    = MODE_PAIR_BS;
            end else begin
              // Lone low surrogates take this path and encode as they stand.
              grp_valid_o = 1'b1;
              grp_o       = encode({5'd0, hex_full});
              mode_d      = MODE_BODY;
            end
          end
        end
        MODE_PAIR_BS, MODE_PAIR_U: begin
          if ((mode_q == MODE_PAIR_BS && text_byte_i == ChBslash) ||
              (mode_q == MODE_PAIR_U && text_byte_i == ChU)) begin
            mode_d = (mode_q == MODE_PAIR_BS) ? MODE_PAIR_U : MODE_HEX;
          end else begin
            grp_valid_o = 1'b1;
            grp_o       = one_result(KIND_ERROR, ERR_UNPAIRED_HI, 8'h00);
            mode_d      = MODE_IDLE;
            held_d      = '0;
            pending_d   = 1'b0;
          end
        end
        default: begin
          if (text_byte_i == ChQuote) begin
            mode_d = MODE_BODY;
          end else begin
            grp_valid_o = 1'b1;
            grp_o       = one_result(KIND_ERROR, ERR_NO_QUOTE, 8'h00);
            mode_d      = MODE_IDLE;
          end
          hex_d     = '0;
          digits_d  = '0;
          held_d    = '0;
          pending_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      hex_q     <= '0;
      digits_q  <= '0;
      held_q    <= '0;
      pending_q <= 1'b0;
    end else if (advance_i) begin
      mode_q    <= mode_d;
      hex_q     <= hex_d;
      digits_q  <= digits_d;
      held_q    <= held_d;
      pending_q <= pending_d;
    end
  end

endmodule

[hw/rtl/jsu_emit.sv]
module jsu_emit
  import jsu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  grp_t      grp_i,
  output logic      can_load_o,
  jsu_out_if.source out_o
);

  logic            busy_q;
  logic [IdxW-1:0] idx_q;
  grp_t            grp_q;
  logic            fire;
  logic            done;

  assign fire       = busy_q && out_o.ready;
  assign done       = fire && (idx_q == grp_q.last_idx);
  assign can_load_o = !busy_q || done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (done) begin
      busy_q <= 1'b0;
    end else if (fire) begin
      idx_q <= idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      grp_q <= grp_i;
    end
  end

  assign out_o.valid       = busy_q;
  assign out_o.out_byte    = grp_q.bytes[idx_q];
  assign out_o.kind        = grp_q.kind;
  assign out_o.error_code  = grp_q.code;
  assign out_o.last_of_run = (idx_q == grp_q.last_idx);

endmodule
